### src/delimited_frame_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimited frame receiver
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_RECEIVER_CORE_MACROS_SVH
`define DELIMITED_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication
`define DFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Constants, types and CRC helper for the delimited frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int FRAME_BUFFER_BYTES = 256;
  localparam int HDR_LEN            = 11;
  localparam int WIN_LEN            = 14;
  localparam int MIN_FRAME          = 26;
  localparam int CNT_W              = $clog2(FRAME_BUFFER_BYTES + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [CNT_W-1:0] CNT_HDR     = CNT_W'(HDR_LEN);
  localparam logic [CNT_W-1:0] CNT_CRC_ON  = CNT_W'(MIN_FRAME - 1);
  localparam logic [CNT_W-1:0] CNT_CHECK   = CNT_W'(MIN_FRAME);
  localparam logic [CNT_W-1:0] CNT_BUF_MAX = CNT_W'(FRAME_BUFFER_BYTES);

  localparam logic [7:0] CHAR_F = 8'h46;

  typedef logic [7:0] byte_t;

  localparam byte_t END_PAT [9] = '{8'h46, 8'h52, 8'h41, 8'h4D, 8'h45,
                                    8'h5F, 8'h45, 8'h4E, 8'h44};
  localparam byte_t MARK_PAT [3] = '{8'h43, 8'h52, 8'h43};

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_FRAME_OK = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic             in_frame;
    logic [3:0]       hdr_cnt;
    logic [CNT_W-1:0] byte_cnt;
  } dfr_state_t;

  // header pattern, one byte per match index
  function automatic byte_t hdr_byte(input logic [3:0] idx);
    byte_t b;
    case (idx)
      4'd0:    b = 8'h46;
      4'd1:    b = 8'h52;
      4'd2:    b = 8'h41;
      4'd3:    b = 8'h4D;
      4'd4:    b = 8'h45;
      4'd5:    b = 8'h5F;
      4'd6:    b = 8'h42;
      4'd7:    b = 8'h45;
      4'd8:    b = 8'h47;
      4'd9:    b = 8'h49;
      4'd10:   b = 8'h4E;
      default: b = 8'h46;
    endcase
    return b;
  endfunction

  // bytewise CRC-16, MSB first, unrolled over eight bits
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

### src/dfr_engine.sv
// ----------------------------------------------------------------------------
// dfr_engine
// Header hunt, frame byte count, tail window, running CRC, tail check and overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_engine import dfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  byte_t      rx_byte,
  output status_t    status,
  output dfr_state_t state
);

  logic             in_frame, in_frame_next;
  logic [3:0]       hdr_cnt, hdr_cnt_next;
  logic [CNT_W-1:0] byte_cnt, byte_cnt_next;
  logic [15:0]      crc, crc_next;
  byte_t            win [WIN_LEN];
  byte_t            win_next [WIN_LEN];
  logic             win_shift;

  logic [3:0]  idx;
  logic        tail_ok;

  always_comb begin
    in_frame_next = in_frame;
    hdr_cnt_next  = hdr_cnt;
    byte_cnt_next = byte_cnt;
    crc_next      = crc;
    win_shift     = 1'b0;
    status        = ST_NONE;
    idx           = (hdr_cnt >= 4'(HDR_LEN)) ? 4'd0 : hdr_cnt;
    tail_ok       = 1'b0;

    for (int i = 0; i < WIN_LEN - 1; i++) win_next[i] = win[i+1];
    win_next[WIN_LEN-1] = rx_byte;

    if (!in_frame) begin
      if (rx_byte == hdr_byte(idx)) begin
        if (idx == 4'(HDR_LEN - 1)) begin
          in_frame_next = 1'b1;
          hdr_cnt_next  = 4'd0;
          byte_cnt_next = CNT_HDR;
          crc_next      = 16'h0000;
        end else begin
          hdr_cnt_next = idx + 4'd1;
        end
      end else begin
        hdr_cnt_next = (rx_byte == CHAR_F) ? 4'd1 : 4'd0;
      end
    end else if (byte_cnt >= CNT_BUF_MAX) begin
      in_frame_next = 1'b0;
      hdr_cnt_next  = 4'd0;
      status        = ST_OVERFLOW;
    end else begin
      win_shift = 1'b1;
      // the byte leaving the window is payload once enough bytes are in
      if (byte_cnt >= CNT_CRC_ON) crc_next = crc16_byte(crc, win[0]);
      byte_cnt_next = byte_cnt + CNT_W'(1);

      tail_ok = (byte_cnt_next >= CNT_CHECK) && ({win_next[3], win_next[4]} == crc_next);
      for (int i = 0; i < 9; i++) if (win_next[5+i] != END_PAT[i]) tail_ok = 1'b0;
      for (int i = 0; i < 3; i++) if (win_next[i] != MARK_PAT[i]) tail_ok = 1'b0;

      if (tail_ok) begin
        in_frame_next = 1'b0;
        hdr_cnt_next  = 4'd0;
        status        = ST_FRAME_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      hdr_cnt  <= 4'd0;
      byte_cnt <= '0;
      crc      <= 16'h0000;
    end else if (step) begin
      in_frame <= in_frame_next;
      hdr_cnt  <= hdr_cnt_next;
      byte_cnt <= byte_cnt_next;
      crc      <= crc_next;
    end
  end

  // window holds data only, no reset
  always_ff @(posedge clk) begin
    if (step && win_shift) begin
      for (int i = 0; i < WIN_LEN; i++) win[i] <= win_next[i];
    end
  end

  assign state = '{in_frame: in_frame, hdr_cnt: hdr_cnt, byte_cnt: byte_cnt};

endmodule

### src/delimited_frame_receiver_core.sv
// Path: an accepted byte is registered at the input, its status in the result register.
// Throughput: one byte per cycle unless out_stall holds the result; the CRC byte update plus
//   14-byte tail compare in dfr_engine lies between input and result registers.
// Reset (rst, synchronous): hunting for header, counters and CRC cleared,
//   both pipeline registers empty. The tail window is not reset.
// ----------------------------------------------------------------------------
// delimited_frame_receiver_core
// Byte-stream frame receiver with header hunt and CRC-16 tail check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "delimited_frame_receiver_core_macros.svh"

module delimited_frame_receiver_core import dfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status
);

  logic       in_full;
  byte_t      in_byte;
  logic       advance;
  logic       accept;
  status_t    status_calc;
  status_t    status_reg;
  dfr_state_t eng_state;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_byte <= rx_byte;
  end

  dfr_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .status  (status_calc),
    .state   (eng_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) status_reg <= status_calc;
  end

  assign status = status_reg;

  // a completed or dropped frame always returns to hunting
  `DFR_ASSERT_NEXT(a_end_hunts, advance && (status_calc != ST_NONE), !eng_state.in_frame, "frame end did not resume hunting")
  `DFR_ASSERT_NOW(a_frame_no_hdr, eng_state.in_frame, eng_state.hdr_cnt == 4'd0, "header count nonzero inside frame")
  `DFR_ASSERT_NOW(a_cnt_range, eng_state.in_frame, (eng_state.byte_cnt >= CNT_HDR) && (eng_state.byte_cnt <= CNT_BUF_MAX), "frame byte count out of range")

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives a byte stream into delimited_frame_receiver_core and checks every
// status against an in-bench model of header hunt, CRC-16 and tail match.
// Traffic mixes noise, broken headers, good frames, bad tails and overflows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import dfr_pkg::*;

// header and end delimiters, first byte in the top bits
localparam logic [8*HDR_LEN-1:0] BEGIN_TEXT = 88'h46_52_41_4D_45_5F_42_45_47_49_4E;
localparam logic [71:0]          END_TEXT   = 72'h46_52_41_4D_45_5F_45_4E_44;
localparam logic [23:0]          MARK_TEXT  = "CRC";

// Tracks receiver state per accepted byte and holds the statuses still owed.
class frame_status_checker;
  logic        in_frame;
  logic [3:0]  begin_idx;
  logic [16:0] byte_cnt;
  byte_t       win [WIN_LEN];
  logic [15:0] run_crc;
  status_t     status_due [$];
  int unsigned errors, n_bytes, n_ok, n_overflow, n_tail_miss;

  function new();
    in_frame = 1'b0;
    begin_idx = 4'd0;
    byte_cnt = 17'd0;
    run_crc = 16'h0000;
    foreach (win[i]) win[i] = 8'h00;
    errors = 0;
    n_bytes = 0;
    n_ok = 0;
    n_overflow = 0;
    n_tail_miss = 0;
  endfunction

  // one byte into CRC-16/XMODEM, bit at a time, MSB first
  static function logic [15:0] crc_next(logic [15:0] c, byte_t b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function void note_byte(byte_t b);
    status_t    st;
    logic [3:0] idx;
    logic       end_seen;
    st = ST_NONE;
    n_bytes++;
    if (!in_frame) begin
      idx = (begin_idx >= HDR_LEN) ? 4'd0 : begin_idx;
      if (b == BEGIN_TEXT[8*(HDR_LEN-1-idx) +: 8]) begin
        idx++;
        if (idx >= HDR_LEN) begin
          in_frame = 1'b1;
          idx = 4'd0;
          byte_cnt = 17'(HDR_LEN);
          run_crc = 16'h0000;
          foreach (win[i]) win[i] = 8'h00;
        end
      end else begin
        idx = (b == BEGIN_TEXT[8*(HDR_LEN-1) +: 8]) ? 4'd1 : 4'd0;
      end
      begin_idx = idx;
    end else if (byte_cnt >= FRAME_BUFFER_BYTES) begin
      in_frame = 1'b0;
      begin_idx = 4'd0;
      st = ST_OVERFLOW;
      n_overflow++;
    end else begin
      // oldest window byte is payload once the window has filled
      if (byte_cnt >= MIN_FRAME - 1) run_crc = crc_next(run_crc, win[0]);
      for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
      win[WIN_LEN-1] = b;
      byte_cnt = byte_cnt + 17'd1;
      end_seen = {win[5], win[6], win[7], win[8], win[9], win[10], win[11], win[12],
                  win[13]} == END_TEXT;
      if (byte_cnt >= MIN_FRAME && end_seen) begin
        if ({win[0], win[1], win[2]} == MARK_TEXT && {win[3], win[4]} == run_crc) begin
          in_frame = 1'b0;
          begin_idx = 4'd0;
          st = ST_FRAME_OK;
          n_ok++;
        end else begin
          n_tail_miss++;
        end
      end
    end
    status_due.push_back(st);
  endfunction

  function int pending();
    return status_due.size();
  endfunction

  function void check_status(logic [1:0] got);
    status_t want;
    if (status_due.size() == 0) begin
      errors++;
      $error("status: expected none outstanding, actual %0d", got);
      return;
    end
    want = status_due.pop_front();
    if (got !== want) begin
      errors++;
      $error("status: expected %0d, actual %0d", want, got);
    end
  endfunction
endclass

module testbench;
  typedef enum {TAIL_GOOD, TAIL_BAD_CRC, TAIL_BAD_MARK} tail_kind_t;

  localparam int ITEMS    = 1650;
  localparam int MAX_BODY = FRAME_BUFFER_BYTES - HDR_LEN - WIN_LEN;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  byte_t      rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;

  bit    quiet_tx, quiet_rx;
  int    stall_left;
  int    bytes_sent;
  int    body_start;
  int    seq_no;
  byte_t tx_q [$];

  frame_status_checker board = new();

  delimited_frame_receiver_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status)
  );

  always #5 clk = ~clk;

  // sample both handshakes on pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_byte(rx_byte);
      if (out_valid && !out_stall) board.check_status(status);
    end
  end

  // result-side backpressure: runs of stall, mostly short
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet_rx && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_tx || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input byte_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic flush_tx();
    foreach (tx_q[i]) send_byte(tx_q[i]);
    tx_q.delete();
  endtask

  // hold off until every owed status has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic byte_t rand_body_byte();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return BEGIN_TEXT[8*$urandom_range(0, HDR_LEN-1) +: 8];
    if (r == 1) return END_TEXT[8*$urandom_range(0, 8) +: 8];
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic void push_begin();
    for (int i = HDR_LEN - 1; i >= 0; i--) tx_q.push_back(BEGIN_TEXT[8*i +: 8]);
    body_start = tx_q.size();
  endfunction

  function automatic void push_body(int n);
    repeat (n) tx_q.push_back(rand_body_byte());
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(25, MAX_BODY);
    return $urandom_range(1, 20);
  endfunction

  // CRC covers everything between the header and this tail
  function automatic void push_tail(tail_kind_t kind);
    logic [15:0] c;
    logic [23:0] mark;
    int          sel;
    c = 16'h0000;
    for (int i = body_start; i < tx_q.size(); i++)
      c = board.crc_next(c, tx_q[i]);
    mark = MARK_TEXT;
    if (kind == TAIL_BAD_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
    if (kind == TAIL_BAD_MARK) begin
      sel = $urandom_range(0, 2);
      mark[8*sel +: 8] = mark[8*sel +: 8] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 2; i >= 0; i--) tx_q.push_back(mark[8*i +: 8]);
    tx_q.push_back(c[15:8]);
    tx_q.push_back(c[7:0]);
    for (int i = 8; i >= 0; i--) tx_q.push_back(END_TEXT[8*i +: 8]);
  endfunction

  initial begin
    int r;
    int n;
    bytes_sent = 0;
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // byte extremes, restart on a stray 'F', then the shortest good frame
    tx_q.push_back(8'h00);
    tx_q.push_back(8'hFF);
    tx_q.push_back(BEGIN_TEXT[8*(HDR_LEN-1) +: 8]);
    push_begin();
    tx_q.push_back(8'hA5);
    push_tail(TAIL_GOOD);
    flush_tx();
    drain();

    seq_no = 0;
    while (bytes_sent < ITEMS) begin
      quiet_tx = ($urandom_range(0, 4) == 0);
      quiet_rx = ($urandom_range(0, 4) == 0);
      if (seq_no == 0) begin
        // longest frame that still fits the buffer
        push_begin();
        push_body(MAX_BODY);
        push_tail(TAIL_GOOD);
      end else if (seq_no % 15 == 7) begin
        push_begin();
        push_body(MAX_BODY + WIN_LEN + $urandom_range(1, 6));
      end else begin
        r = $urandom_range(0, 9);
        case (r)
          0, 1: begin
            push_body($urandom_range(1, 12));
          end
          2: begin
            n = $urandom_range(1, HDR_LEN - 1);
            for (int i = 0; i < n; i++) tx_q.push_back(BEGIN_TEXT[8*(HDR_LEN-1-i) +: 8]);
            tx_q.push_back(rand_body_byte());
          end
          3, 4, 5, 6: begin
            push_begin();
            push_body(pick_len());
            push_tail(TAIL_GOOD);
          end
          default: begin
            push_begin();
            push_body($urandom_range(1, 20));
            push_tail($urandom_range(0, 1) ? TAIL_BAD_CRC : TAIL_BAD_MARK);
            push_body($urandom_range(0, 20));
            push_tail(TAIL_GOOD);
          end
        endcase
      end
      flush_tx();
      if (seq_no % 10 == 9) drain();
      seq_no++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d bytes in %0d sequences: %0d frames accepted,", board.n_bytes,
             seq_no, board.n_ok);
    $display("%0d tail mismatches, %0d buffer overflows.", board.n_tail_miss, board.n_overflow);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/dfr_pkg.sv
src/dfr_engine.sv
src/delimited_frame_receiver_core.sv
dv/testbench.sv
